// File: rtl/epsm_pkg.sv
// Package for the encoder period speed meter: widths, speed constants,
// register addresses, sequencer states and the divider command word.
// No dependencies.
`default_nettype none

package epsm_pkg;

   localparam int TS_W    = 32;
   localparam int PPR_W   = 16;
   localparam int SPEED_W = 38;
   localparam int FRAC_W  = 8;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // Q16 speed constants; quotient bits follow from the largest result
   localparam int K_W   = 45;
   localparam int Q_W   = 37;
   localparam int P_W   = PPR_W + TS_W;
   localparam int REM_W = P_W + FRAC_W + 1;
   localparam int CNT_W = 6;

   localparam logic [K_W-1:0] K_DEG = 45'd23592960000000;
   localparam logic [K_W-1:0] K_RAD = 45'd411774832291;
   localparam logic [Q_W-1:0] SPEED_MAX = 37'd92160000000;

   localparam logic [PPR_W-1:0] PPR_RESET   = 16'd500;
   localparam logic [TS_W-1:0]  LIMIT_RESET = 32'd227633;
   localparam logic [TS_W-1:0]  PREV_RESET  = 32'd20;
   localparam logic [TS_W-1:0]  HELD_RESET  = 32'd1000000;

   localparam logic [ADDR_W-1:0] ADDR_PPR   = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_UNIT  = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_LIMIT = 4'h8;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL_LP = 8'b0000_0010,
      ST_MUL_LO = 8'b0000_0100,
      ST_MUL_HI = 8'b0000_1000,
      ST_CHECK  = 8'b0001_0000,
      ST_MUL_P  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic start;
      logic degrees;
   } div_cmd_type;

endpackage

`default_nettype wire

// File: rtl/encoder_period_speed_meter.sv
// Each accepted edge word makes four passes through the shared 32x32 multiplier,
// one compare, then the 37-step restoring divider, and its result word is then
// registered in ST_FINISH.
// The next edge is taken once the result is registered; a stalled result holds the next one.
// Reset (synchronous) restores the registers and the edge history, empties the output.
// Depends on epsm_pkg and epsm_div.
`default_nettype none

module encoder_period_speed_meter (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [epsm_pkg::TS_W-1:0]            req_timestamp_us,
   input  wire                                  req_b_is_low,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [epsm_pkg::SPEED_W-1:0]  rsp_speed_q8,
   output logic [epsm_pkg::TS_W-1:0]            rsp_period_us,
   output logic                                 rsp_accepted,
   output logic                                 rsp_reverse,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [epsm_pkg::ADDR_W-1:0]          csr_paddr,
   input  wire  [epsm_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [epsm_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready
);

   epsm_pkg::state_type                 state_ff, state_in;
   logic [epsm_pkg::PPR_W-1:0]          ppr_ff, ppr_in;
   logic                                deg_ff, deg_in;
   logic [epsm_pkg::TS_W-1:0]           lim_ff, lim_in;
   logic [epsm_pkg::TS_W-1:0]           last_ff, last_in;
   logic [epsm_pkg::TS_W-1:0]           prev_ff, prev_in;
   logic [epsm_pkg::TS_W-1:0]           held_ff, held_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic [epsm_pkg::TS_W-1:0]           cur_ff, cur_in;
   logic [epsm_pkg::TS_W-1:0]           dif_ff, dif_in;
   logic                                rev_ff, rev_in;
   logic                                ok_ff, ok_in;
   logic [2*epsm_pkg::TS_W-1:0]         a_ff, a_in;
   logic [2*epsm_pkg::TS_W-1:0]         lo_ff, lo_in;
   logic [2*epsm_pkg::TS_W-1:0]         hi_ff, hi_in;
   logic signed [epsm_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [epsm_pkg::TS_W-1:0]           period_ff, period_in;
   logic                                acc_ff, acc_in;
   logic                                revo_ff, revo_in;

   logic [epsm_pkg::TS_W-1:0]           mul_a, mul_b;
   logic [2*epsm_pkg::TS_W-1:0]         mul_p;
   logic [2*epsm_pkg::TS_W-1:0]         r_hi;
   logic                                chk_ok;
   logic                                csr_wr;
   logic [epsm_pkg::Q_W-1:0]            mag;
   logic [epsm_pkg::SPEED_W-1:0]        mag_x;

   epsm_pkg::div_cmd_type               div_cmd;
   logic                                div_done;
   logic [epsm_pkg::Q_W-1:0]            div_q;

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         epsm_pkg::ST_MUL_LP: begin
            mul_a = lim_ff;
            mul_b = prev_ff;
         end
         epsm_pkg::ST_MUL_LO: begin
            mul_a = a_ff[epsm_pkg::TS_W-1:0];
            mul_b = cur_ff;
         end
         epsm_pkg::ST_MUL_HI: begin
            mul_a = a_ff[2*epsm_pkg::TS_W-1:epsm_pkg::TS_W];
            mul_b = cur_ff;
         end
         epsm_pkg::ST_MUL_P: begin
            mul_a = epsm_pkg::TS_W'(ppr_ff);
            mul_b = held_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign r_hi   = hi_ff + {{epsm_pkg::TS_W{1'b0}}, lo_ff[2*epsm_pkg::TS_W-1:epsm_pkg::TS_W]};
   assign chk_ok = (cur_ff != '0) && ({{epsm_pkg::TS_W{1'b0}}, dif_ff} <= r_hi);

   assign div_cmd.start   = (state_ff == epsm_pkg::ST_MUL_P);
   assign div_cmd.degrees = deg_ff;

   epsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .divisor  (mul_p[epsm_pkg::P_W-1:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   assign mag   = (a_ff[epsm_pkg::P_W-1:0] == '0) ? epsm_pkg::SPEED_MAX : div_q;
   assign mag_x = {1'b0, mag};

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      state_in     = state_ff;
      ppr_in       = ppr_ff;
      deg_in       = deg_ff;
      lim_in       = lim_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      cur_in       = cur_ff;
      dif_in       = dif_ff;
      rev_in       = rev_ff;
      ok_in        = ok_ff;
      a_in         = a_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      speed_in     = speed_ff;
      period_in    = period_ff;
      acc_in       = acc_ff;
      revo_in      = revo_ff;

      if (csr_wr) begin
         unique case (csr_paddr)
            epsm_pkg::ADDR_PPR:   ppr_in = csr_pwdata[epsm_pkg::PPR_W-1:0];
            epsm_pkg::ADDR_UNIT:  deg_in = csr_pwdata[0];
            epsm_pkg::ADDR_LIMIT: lim_in = csr_pwdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         epsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_timestamp_us - last_ff;
               rev_in   = req_b_is_low;
               last_in  = req_timestamp_us;
               state_in = epsm_pkg::ST_MUL_LP;
            end
         end
         epsm_pkg::ST_MUL_LP: begin
            a_in     = mul_p;
            dif_in   = (prev_ff > cur_ff) ? (prev_ff - cur_ff) : (cur_ff - prev_ff);
            state_in = epsm_pkg::ST_MUL_LO;
         end
         epsm_pkg::ST_MUL_LO: begin
            lo_in    = mul_p;
            state_in = epsm_pkg::ST_MUL_HI;
         end
         epsm_pkg::ST_MUL_HI: begin
            hi_in    = mul_p;
            state_in = epsm_pkg::ST_CHECK;
         end
         epsm_pkg::ST_CHECK: begin
            ok_in   = chk_ok;
            prev_in = cur_ff;
            if (chk_ok) begin
               held_in = cur_ff;
            end
            state_in = epsm_pkg::ST_MUL_P;
         end
         epsm_pkg::ST_MUL_P: begin
            a_in     = mul_p;
            state_in = epsm_pkg::ST_DIV;
         end
         epsm_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = epsm_pkg::ST_FINISH;
            end
         end
         epsm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               speed_in     = rev_ff ? -$signed(mag_x) : $signed(mag_x);
               period_in    = held_ff;
               acc_in       = ok_ff;
               revo_in      = rev_ff;
               rsp_valid_in = 1'b1;
               state_in     = epsm_pkg::ST_IDLE;
            end
         end
         default: state_in = epsm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epsm_pkg::ST_IDLE;
         ppr_ff       <= epsm_pkg::PPR_RESET;
         deg_ff       <= 1'b0;
         lim_ff       <= epsm_pkg::LIMIT_RESET;
         last_ff      <= '0;
         prev_ff      <= epsm_pkg::PREV_RESET;
         held_ff      <= epsm_pkg::HELD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ppr_ff       <= ppr_in;
         deg_ff       <= deg_in;
         lim_ff       <= lim_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      dif_ff    <= dif_in;
      rev_ff    <= rev_in;
      ok_ff     <= ok_in;
      a_ff      <= a_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      speed_ff  <= speed_in;
      period_ff <= period_in;
      acc_ff    <= acc_in;
      revo_ff   <= revo_in;
   end

   always_comb begin
      unique case (csr_paddr)
         epsm_pkg::ADDR_PPR:   csr_prdata = epsm_pkg::DATA_W'(ppr_ff);
         epsm_pkg::ADDR_UNIT:  csr_prdata = epsm_pkg::DATA_W'(deg_ff);
         epsm_pkg::ADDR_LIMIT: csr_prdata = lim_ff;
         default:              csr_prdata = '0;
      endcase
   end

   assign csr_pready    = 1'b1;
   assign req_ready     = (state_ff == epsm_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_speed_q8  = speed_ff;
   assign rsp_period_us = period_ff;
   assign rsp_accepted  = acc_ff;
   assign rsp_reverse   = revo_ff;

endmodule

`default_nettype wire

// File: rtl/epsm_div.sv
// Restoring divider for the speed magnitude: Q16 speed constant over
// (pulses per rev * period) << 8, one quotient bit per cycle.
// Depends on epsm_pkg.
`default_nettype none

module epsm_div (
   input  wire                             clock,
   input  wire                             reset,
   input  wire  epsm_pkg::div_cmd_type     cmd,
   input  wire  [epsm_pkg::P_W-1:0]        divisor,
   output logic                            done,
   output logic [epsm_pkg::Q_W-1:0]        quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [epsm_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [epsm_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [epsm_pkg::Q_W-1:0]         k_ff, k_in;
   logic [epsm_pkg::Q_W-1:0]         q_ff, q_in;
   logic [epsm_pkg::P_W-1:0]         den_ff, den_in;
   logic [epsm_pkg::K_W-1:0]         k_sel;
   logic [epsm_pkg::REM_W-1:0]       rem_sh;
   logic [epsm_pkg::REM_W-1:0]       den_x;
   logic                             ge;

   assign k_sel  = cmd.degrees ? epsm_pkg::K_DEG : epsm_pkg::K_RAD;
   assign rem_sh = {rem_ff[epsm_pkg::REM_W-2:0], k_ff[epsm_pkg::Q_W-1]};
   assign den_x  = {1'b0, den_ff, {epsm_pkg::FRAC_W{1'b0}}};
   assign ge     = (rem_sh >= den_x);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      k_in    = k_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = epsm_pkg::CNT_W'(epsm_pkg::Q_W - 1);
         rem_in  = epsm_pkg::REM_W'(k_sel[epsm_pkg::K_W-1:epsm_pkg::Q_W]);
         k_in    = k_sel[epsm_pkg::Q_W-1:0];
         q_in    = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - den_x) : rem_sh;
         k_in   = {k_ff[epsm_pkg::Q_W-2:0], 1'b0};
         q_in   = {q_ff[epsm_pkg::Q_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      k_ff   <= k_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: rtl/epsm_checker.sv
// Port-level checks for the encoder period speed meter, bound to the top level.
// Depends on epsm_pkg and encoder_period_speed_meter.
`default_nettype none

module epsm_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_ready,
   input wire                                  rsp_valid,
   input wire                                  rsp_ready,
   input wire signed [epsm_pkg::SPEED_W-1:0]   rsp_speed_q8,
   input wire [epsm_pkg::TS_W-1:0]             rsp_period_us,
   input wire                                  rsp_reverse
);

   // drop ready after an accepted edge word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held high after an accepted edge word");

   // no result can appear in the cycle after acceptance when none was pending
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
      else $error("result word appeared too early");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_period_us != '0))
      else $error("held period of zero reported");

   a_sign_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_speed_q8[epsm_pkg::SPEED_W-1] == rsp_reverse)
                     || (rsp_speed_q8 == '0)))
      else $error("speed sign disagrees with direction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_speed_q8)))
      else $error("stalled result word changed");

endmodule

bind encoder_period_speed_meter epsm_checker u_epsm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_speed_q8 (rsp_speed_q8),
   .rsp_period_us(rsp_period_us),
   .rsp_reverse  (rsp_reverse)
);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for encoder_period_speed_meter: drives edge words and APB
// register writes, predicts each speed word and compares it field by field.
// Depends on epsm_pkg and the meter RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic signed [epsm_pkg::SPEED_W-1:0] speed;
      logic [epsm_pkg::TS_W-1:0]           period;
      logic                                accepted;
      logic                                reverse;
   } speed_word_type;

   class speed_scoreboard;
      logic [epsm_pkg::PPR_W-1:0] ppr;
      logic                       unit_deg;
      logic [epsm_pkg::TS_W-1:0]  limit;
      logic [epsm_pkg::TS_W-1:0]  last_ts;
      logic [epsm_pkg::TS_W-1:0]  prev_iv;
      logic [epsm_pkg::TS_W-1:0]  held;
      speed_word_type             speed_words[$];
      int                         errors;
      int                         words_seen;

      function new();
         ppr = epsm_pkg::PPR_RESET;
         unit_deg = 1'b0;
         limit = epsm_pkg::LIMIT_RESET;
         last_ts = '0;
         prev_iv = epsm_pkg::PREV_RESET;
         held = epsm_pkg::HELD_RESET;
         errors = 0;
         words_seen = 0;
      endfunction

      function void write_reg(logic [epsm_pkg::ADDR_W-1:0] addr,
                              logic [epsm_pkg::DATA_W-1:0] data);
         case (addr)
            epsm_pkg::ADDR_PPR:   ppr = data[epsm_pkg::PPR_W-1:0];
            epsm_pkg::ADDR_UNIT:  unit_deg = data[0];
            epsm_pkg::ADDR_LIMIT: limit = data;
            default: ;
         endcase
      endfunction

      function void note_edge(logic [epsm_pkg::TS_W-1:0] ts, logic b_low);
         logic [epsm_pkg::TS_W-1:0] iv;
         logic [epsm_pkg::TS_W-1:0] diff;
         logic [127:0]              bound;
         logic [127:0]              num;
         logic [127:0]              den;
         logic [127:0]              mag;
         logic                      ok;
         speed_word_type            w;
         iv = ts - last_ts;
         diff = (prev_iv > iv) ? prev_iv - iv : iv - prev_iv;
         bound = (128'(limit) * 128'(prev_iv) * 128'(iv)) >> 32;
         ok = (iv != '0) && (128'(diff) <= bound);
         if (ok) held = iv;
         prev_iv = iv;
         last_ts = ts;
         if (ppr == '0) begin
            mag = 128'(epsm_pkg::SPEED_MAX);
         end else begin
            num = 128'(unit_deg ? epsm_pkg::K_DEG : epsm_pkg::K_RAD) << epsm_pkg::FRAC_W;
            den = (128'(ppr) * 128'(held)) << 16;
            mag = num / den;
            if (mag > 128'(epsm_pkg::SPEED_MAX)) mag = 128'(epsm_pkg::SPEED_MAX);
         end
         w.speed = b_low ? (38'd0 - mag[epsm_pkg::SPEED_W-1:0]) : mag[epsm_pkg::SPEED_W-1:0];
         w.period = held;
         w.accepted = ok;
         w.reverse = b_low;
         speed_words.push_back(w);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("word %0d: %s is %0h, predicted %0h", words_seen, what, got, want);
         errors++;
      endtask

      task check_word(speed_word_type got);
         speed_word_type want;
         words_seen++;
         if (speed_words.size() == 0) begin
            report_mismatch("unexpected word, speed", 64'(got.speed), 64'(0));
         end else begin
            want = speed_words.pop_front();
            if (got.speed !== want.speed)
               report_mismatch("speed", 64'(got.speed), 64'(want.speed));
            if (got.period !== want.period)
               report_mismatch("period", 64'(got.period), 64'(want.period));
            if (got.accepted !== want.accepted)
               report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
            if (got.reverse !== want.reverse)
               report_mismatch("reverse", 64'(got.reverse), 64'(want.reverse));
         end
      endtask

      function int pending();
         return speed_words.size();
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [epsm_pkg::TS_W-1:0]          req_timestamp_us = '0;
   logic                               req_b_is_low = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [epsm_pkg::SPEED_W-1:0] rsp_speed_q8;
   logic [epsm_pkg::TS_W-1:0]          rsp_period_us;
   logic                               rsp_accepted;
   logic                               rsp_reverse;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [epsm_pkg::ADDR_W-1:0]        csr_paddr = '0;
   logic [epsm_pkg::DATA_W-1:0]        csr_pwdata = '0;
   logic [epsm_pkg::DATA_W-1:0]        csr_prdata;
   logic                               csr_pready;

   speed_scoreboard           sb = new();
   int                        cycles = 0;
   int                        req_max_gap = 12;
   int                        rsp_max_stall = 12;
   int                        stall_left = 0;
   logic [epsm_pkg::TS_W-1:0] ts_now = '0;

   encoder_period_speed_meter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_timestamp_us (req_timestamp_us),
      .req_b_is_low     (req_b_is_low),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_speed_q8     (rsp_speed_q8),
      .rsp_period_us    (rsp_period_us),
      .rsp_accepted     (rsp_accepted),
      .rsp_reverse      (rsp_reverse),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         sb.check_word('{rsp_speed_q8, rsp_period_us, rsp_accepted, rsp_reverse});
         n = $urandom_range(rsp_max_stall, 0);
         stall_left <= n;
         rsp_ready <= (n == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end
   end

   task send_edge(logic [epsm_pkg::TS_W-1:0] ts, logic b_low);
      int gap;
      gap = $urandom_range(req_max_gap, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timestamp_us <= ts;
      req_b_is_low <= b_low;
      do @(posedge clock); while (!req_ready);
      sb.note_edge(ts, b_low);
      ts_now = ts;
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task csr_write(logic [epsm_pkg::ADDR_W-1:0] addr, logic [epsm_pkg::DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.write_reg(addr, data);
   endtask

   task set_meter(logic [epsm_pkg::PPR_W-1:0] ppr, logic unit_deg,
                  logic [epsm_pkg::TS_W-1:0] limit);
      csr_write(epsm_pkg::ADDR_PPR, epsm_pkg::DATA_W'(ppr));
      csr_write(epsm_pkg::ADDR_UNIT, epsm_pkg::DATA_W'(unit_deg));
      csr_write(epsm_pkg::ADDR_LIMIT, limit);
   endtask

   task run_edges(int n_items);
      int                        count;
      int                        run_len;
      int                        bits;
      int                        kind;
      logic [epsm_pkg::TS_W-1:0] span;
      logic [epsm_pkg::TS_W-1:0] base;
      logic [epsm_pkg::TS_W-1:0] jit;
      logic [epsm_pkg::TS_W-1:0] iv;
      count = 0;
      while (count < n_items) begin
         run_len = $urandom_range(30, 5);
         bits = ($urandom_range(9, 0) < 7) ? $urandom_range(20, 0) : $urandom_range(31, 0);
         span = 32'd1 << bits;
         base = $urandom_range(span, 1);
         for (int i = 0; i < run_len && count < n_items; i++) begin
            kind = $urandom_range(99, 0);
            jit = $urandom_range(base >> 6, 0);
            if (kind < 5)
               iv = '0;
            else if (kind < 10)
               iv = $urandom;
            else
               iv = $urandom_range(1, 0) ? base + jit : base - jit;
            if (kind >= 10 && kind < 14)
               send_edge($urandom, 1'($urandom_range(1, 0)));
            else
               send_edge(ts_now + iv, 1'($urandom_range(1, 0)));
            count++;
         end
      end
   endtask

   initial begin
      logic [epsm_pkg::PPR_W-1:0] ppr;
      logic [epsm_pkg::TS_W-1:0]  limit;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: first edge, steady period, zero interval, wrap
      send_edge(32'd1000000, 1'b0);
      send_edge(32'd2000000, 1'b1);
      send_edge(32'd2000000, 1'b0);
      send_edge(32'd2001000, 1'b1);
      send_edge(32'd2002000, 1'b0);
      send_edge(32'd2003010, 1'b0);
      send_edge(32'hFFFF_FFF0, 1'b1);
      send_edge(32'h0000_0010, 1'b0);
      send_edge(32'hFFFF_FFFF, 1'b1);
      send_edge(32'h0000_0000, 1'b0);
      send_edge(32'h0000_0001, 1'b1);
      drain();

      // one pulse per rev, degrees, widest limit: speed hits saturation
      set_meter(16'd1, 1'b1, 32'hFFFF_FFFF);
      send_edge(32'd2, 1'b0);
      send_edge(32'd3, 1'b1);
      send_edge(32'h8000_0003, 1'b0);
      drain();

      set_meter(16'd0, 1'b0, 32'hFFFF_FFFF);
      send_edge(ts_now + 32'd5, 1'b1);
      send_edge(ts_now + 32'd5, 1'b0);
      drain();

      set_meter(16'hFFFF, 1'b1, 32'd0);
      send_edge(ts_now + 32'd1000, 1'b0);
      send_edge(ts_now + 32'd1000, 1'b1);
      send_edge(ts_now + 32'd1001, 1'b0);
      send_edge(ts_now + 32'hFFFF_FFFF, 1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: ppr = 16'd1;
            1: ppr = 16'hFFFF;
            2: ppr = 16'd0;
            3: ppr = epsm_pkg::PPR_RESET;
            default: ppr = epsm_pkg::PPR_W'($urandom_range(65535, 1));
         endcase
         case (p)
            0: limit = epsm_pkg::LIMIT_RESET;
            3: limit = 32'd0;
            4: limit = 32'hFFFF_FFFF;
            5: limit = $urandom;
            default: limit = $urandom_range(4000000, 0);
         endcase
         req_max_gap = (p % 3 == 1) ? 0 : 12;
         rsp_max_stall = (p % 4 == 2) ? 0 : 12;
         set_meter(ppr, p[0], limit);
         run_edges(142);
         drain();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
